[rtl/core/vna_pkg.sv]
// ----------------------------------------------------------------------------
// vna_pkg
// Shared widths, operation codes and interface types of the vertex normal
// accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 256;
  localparam int IDX_W  = 8;
  localparam int POS_W  = 16;
  localparam int SUM_W  = 24;
  localparam int NRM_W  = 16;
  localparam int MAG_W  = 36;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [2:0][MAG_W-1:0] vec;
  } unit_req_t;

  typedef struct packed {
    logic                  done;
    logic                  zero;
    logic [2:0][NRM_W-1:0] n;
  } unit_rsp_t;

endpackage

`default_nettype wire

[rtl/core/vna_ram.sv]
// ----------------------------------------------------------------------------
// vna_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/vna_unit.sv]
// ----------------------------------------------------------------------------
// vna_unit
// Iterative vector normalizer: block shift, sum of squares, bit-serial square
// root and restoring division of each component to a Q1.14 unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module vna_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vna_pkg::unit_req_t  req,
  output vna_pkg::unit_rsp_t       rsp
);
  import vna_pkg::*;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DIVI, U_DIV, U_STORE
  } ustate_t;

  ustate_t               state_r;
  logic [2:0][MAG_W-1:0] mag_r;
  logic [2:0]            neg_r;
  logic [MAG_W-1:0]      m_r;
  logic [59:0]           prod_r;
  logic [62:0]           l2_r;
  logic [62:0]           x_r;
  logic [62:0]           r_r;
  logic [62:0]           bit_r;
  logic [4:0]            cnt_r;
  logic [1:0]            i_r;
  logic [31:0]           rem_r;
  logic [44:0]           dvd_r;
  logic [14:0]           q_r;
  logic [2:0][NRM_W-1:0] n_r;
  logic                  done_r;
  logic                  zero_r;

  logic [2:0][MAG_W-1:0] abs_v;
  logic [MAG_W-1:0]      max_v;
  logic [62:0]           rb;
  logic [31:0]           t;
  logic [31:0]           len32;
  logic [44:0]           dvd_init;
  logic [14:0]           qc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = req.vec[i][MAG_W-1] ? (~req.vec[i] + 1'b1) : req.vec[i];
    end
    max_v = abs_v[0];
    if (abs_v[1] > max_v) max_v = abs_v[1];
    if (abs_v[2] > max_v) max_v = abs_v[2];
    rb       = r_r + bit_r;
    len32    = {1'b0, r_r[30:0]};
    t        = {rem_r[30:0], dvd_r[14]};
    dvd_init = {1'b0, mag_r[i_r][29:0], 14'd0} + 45'(r_r[30:1]);
    qc       = (q_r > 15'd16384) ? 15'd16384 : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (req.start) begin
            mag_r <= abs_v;
            neg_r <= {req.vec[2][MAG_W-1], req.vec[1][MAG_W-1], req.vec[0][MAG_W-1]};
            m_r   <= max_v;
            if (max_v == '0) begin
              done_r <= 1'b1;
              zero_r <= 1'b1;
              n_r    <= '0;
            end else begin
              state_r <= U_SHIFT;
            end
          end
        end
        U_SHIFT: begin
          if (m_r[MAG_W-1:30] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
            m_r <= m_r >> 1;
          end else if (!m_r[29]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
            m_r <= m_r << 1;
          end else begin
            cnt_r   <= '0;
            l2_r    <= '0;
            state_r <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt_r < 5'd3) begin
            prod_r <= mag_r[cnt_r[1:0]][29:0] * mag_r[cnt_r[1:0]][29:0];
          end
          if (cnt_r != 5'd0) begin
            l2_r <= l2_r + 63'(prod_r);
          end
          if (cnt_r == 5'd3) begin
            x_r     <= l2_r + 63'(prod_r);
            r_r     <= '0;
            bit_r   <= 63'd1 << 62;
            cnt_r   <= '0;
            state_r <= U_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_SQRT: begin
          if (x_r >= rb) begin
            x_r <= x_r - rb;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            i_r     <= '0;
            state_r <= U_DIVI;
          end
        end
        U_DIVI: begin
          dvd_r   <= dvd_init;
          rem_r   <= {2'b00, dvd_init[44:15]};
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= U_DIV;
        end
        U_DIV: begin
          dvd_r <= dvd_r << 1;
          if (t >= len32) begin
            rem_r <= t - len32;
            q_r   <= {q_r[13:0], 1'b1};
          end else begin
            rem_r <= t;
            q_r   <= {q_r[13:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd14) begin
            state_r <= U_STORE;
          end
        end
        U_STORE: begin
          n_r[i_r] <= neg_r[i_r] ? (~{1'b0, qc} + 1'b1) : {1'b0, qc};
          if (i_r == 2'd2) begin
            done_r  <= 1'b1;
            zero_r  <= 1'b0;
            state_r <= U_IDLE;
          end else begin
            i_r     <= i_r + 2'd1;
            state_r <= U_DIVI;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.zero = zero_r;
  assign rsp.n    = n_r;

endmodule

`default_nettype wire

[rtl/core/vertex_normal_accumulator_core.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_core
// Smooth vertex normals in fixed point: position store, face normal
// accumulation with saturation and normalized vertex normal readout.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge where start is high and busy is low.
// in_op selects a position write, a triangle add or a normal read; the
// vertex index and position ports carry its operands. Every command gives
// exactly one result, shown for one cycle with out_valid high; the receiver
// cannot hold it off. busy stays high from acceptance until the cycle the
// result is shown, and the next command can be taken in that same cycle, so
// a new command is never taken before the last one has its result. A write,
// an unused operation code or an out-of-range index ends in the dispatch
// state; a normal read and a triangle pass through the vector normalizer,
// with up to 29 block shifts, one per cycle, a 32-step square root and three
// 15-step divisions, and the triangle adds three position reads, six products
// through one multiplier and, unless degenerate, three read-modify-write
// passes over the sum memory.
// Reset clears the per-vertex valid bits, so every sum reads as zero after
// reset without a clearing pass; positions are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_normal_accumulator_core #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        in_op,
  input  wire logic [vna_pkg::IDX_W-1:0]         in_vertex_a,
  input  wire logic [vna_pkg::IDX_W-1:0]         in_vertex_b,
  input  wire logic [vna_pkg::IDX_W-1:0]         in_vertex_c,
  input  wire logic signed [vna_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [vna_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic signed [vna_pkg::POS_W-1:0]  in_pos_z,
  output logic                                   out_valid,
  output logic signed [vna_pkg::NRM_W-1:0]       out_normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]       out_normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]       out_normal_z,
  output logic                                   out_zero_length
);
  import vna_pkg::*;

  localparam int DEPTH = (VERTEX_COUNT > 256) ? 256 : VERTEX_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 3 * POS_W;
  localparam int SW    = 3 * SUM_W;

  typedef enum logic [3:0] {
    T_IDLE, T_DISP, T_PA, T_PB, T_PC, T_MUL, T_USTART, T_UWAIT,
    T_SUMRD, T_SUMWR, T_SR
  } tstate_t;

  tstate_t               state_r;
  logic                  busy_r;
  logic [1:0]            op_r;
  logic [2:0][IDX_W-1:0] idx_r;
  logic [PW-1:0]         wpos_r;
  logic [PW-1:0]         pa_r;
  logic [PW-1:0]         pb_r;
  logic [PW-1:0]         pc_r;
  logic [2:0]            k_r;
  logic [1:0]            j_r;
  logic signed [33:0]    prod_r;
  logic [2:0][MAG_W-1:0] vec_r;
  logic [2:0][NRM_W-1:0] fn_r;
  logic [DEPTH-1:0]      vld_r;
  logic                  vld_rd_r;
  logic                  uwait_tri_r;
  logic                  out_valid_r;
  logic [2:0][NRM_W-1:0] out_n_r;
  logic                  out_zero_r;

  logic                  pos_we;
  logic [AW-1:0]         pos_raddr;
  logic [PW-1:0]         pos_rdata;
  logic                  sum_we;
  logic [AW-1:0]         sum_addr_rd;
  logic [AW-1:0]         sum_waddr;
  logic [SW-1:0]         sum_wdata;
  logic [SW-1:0]         sum_rdata;
  logic [SW-1:0]         sum_old;
  unit_req_t             ureq;
  unit_rsp_t             ursp;

  logic                  a_ok;
  logic                  b_ok;
  logic                  c_ok;
  logic [1:0]            ia;
  logic [1:0]            ib;
  logic signed [16:0]    opa;
  logic signed [16:0]    opb;
  logic [2:0]            kk;
  logic [IDX_W-1:0]      corner;

  function automatic logic signed [POS_W-1:0] comp(input logic [PW-1:0] p,
                                                   input logic [1:0] i);
    logic signed [POS_W-1:0] v;
    case (i)
      2'd0:    v = p[PW-1 -: POS_W];
      2'd1:    v = p[PW-POS_W-1 -: POS_W];
      default: v = p[POS_W-1:0];
    endcase
    return v;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [NRM_W-1:0] d);
    logic signed [SUM_W:0] tt;
    logic [SUM_W-1:0]      res;
    tt = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-NRM_W){d[NRM_W-1]}}, d});
    if (tt[SUM_W] != tt[SUM_W-1]) begin
      res = tt[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      res = tt[SUM_W-1:0];
    end
    return res;
  endfunction

  vna_ram #(.W(PW), .DEPTH(DEPTH), .AW(AW)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (idx_r[0][AW-1:0]),
    .wdata (wpos_r),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  vna_ram #(.W(SW), .DEPTH(DEPTH), .AW(AW)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_addr_rd),
    .rdata (sum_rdata)
  );

  vna_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .rsp   (ursp)
  );

  always_comb begin
    a_ok   = 32'(idx_r[0]) < VERTEX_COUNT;
    b_ok   = 32'(idx_r[1]) < VERTEX_COUNT;
    c_ok   = 32'(idx_r[2]) < VERTEX_COUNT;
    corner = idx_r[j_r];

    pos_we    = (state_r == T_DISP) && (op_r == OP_WRITE) && a_ok;
    pos_raddr = idx_r[0][AW-1:0];
    if (state_r == T_PA) pos_raddr = idx_r[1][AW-1:0];
    if (state_r == T_PB) pos_raddr = idx_r[2][AW-1:0];

    sum_addr_rd = (state_r == T_SUMRD) ? corner[AW-1:0] : idx_r[0][AW-1:0];
    sum_waddr   = corner[AW-1:0];
    sum_we      = (state_r == T_SUMWR);
    sum_old     = vld_rd_r ? sum_rdata : '0;
    sum_wdata   = {sat_add(sum_old[SW-1 -: SUM_W], fn_r[0]),
                   sat_add(sum_old[SW-SUM_W-1 -: SUM_W], fn_r[1]),
                   sat_add(sum_old[SUM_W-1:0], fn_r[2])};

    case (k_r)
      3'd0:    begin ia = 2'd1; ib = 2'd2; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd0; end
    endcase
    opa = 17'(comp(pb_r, ia)) - 17'(comp(pa_r, ia));
    opb = 17'(comp(pc_r, ib)) - 17'(comp(pa_r, ib));
    kk  = k_r - 3'd1;

    ureq.start = (state_r == T_USTART);
    ureq.vec   = vec_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      busy_r      <= 1'b0;
      vld_r       <= '0;
      vld_rd_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      vld_rd_r    <= vld_r[sum_addr_rd];
      case (state_r)
        T_IDLE: begin
          if (start && !busy_r) begin
            busy_r  <= 1'b1;
            op_r    <= in_op;
            idx_r   <= {in_vertex_c, in_vertex_b, in_vertex_a};
            wpos_r  <= {in_pos_x, in_pos_y, in_pos_z};
            state_r <= T_DISP;
          end
        end
        T_DISP: begin
          out_n_r <= '0;
          case (op_r)
            OP_TRI: begin
              if (a_ok && b_ok && c_ok) begin
                state_r <= T_PA;
              end else begin
                out_zero_r  <= 1'b1;
                out_valid_r <= 1'b1;
                busy_r      <= 1'b0;
                state_r     <= T_IDLE;
              end
            end
            OP_READ: begin
              if (a_ok) begin
                state_r <= T_SR;
              end else begin
                out_zero_r  <= 1'b1;
                out_valid_r <= 1'b1;
                busy_r      <= 1'b0;
                state_r     <= T_IDLE;
              end
            end
            default: begin
              out_zero_r  <= 1'b0;
              out_valid_r <= 1'b1;
              busy_r      <= 1'b0;
              state_r     <= T_IDLE;
            end
          endcase
        end
        T_PA: begin
          pa_r    <= pos_rdata;
          state_r <= T_PB;
        end
        T_PB: begin
          pb_r    <= pos_rdata;
          state_r <= T_PC;
        end
        T_PC: begin
          pc_r    <= pos_rdata;
          k_r     <= '0;
          vec_r   <= '0;
          state_r <= T_MUL;
        end
        T_MUL: begin
          if (k_r != 3'd6) begin
            prod_r <= opa * opb;
          end
          if (k_r != 3'd0) begin
            if (kk[0]) begin
              vec_r[kk[2:1]] <= vec_r[kk[2:1]] - {{(MAG_W-34){prod_r[33]}}, prod_r};
            end else begin
              vec_r[kk[2:1]] <= vec_r[kk[2:1]] + {{(MAG_W-34){prod_r[33]}}, prod_r};
            end
          end
          if (k_r == 3'd6) begin
            uwait_tri_r <= 1'b1;
            state_r     <= T_USTART;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        T_SR: begin
          for (int i = 0; i < 3; i++) begin
            vec_r[i] <= {{(MAG_W-SUM_W){sum_old[SW-1-i*SUM_W]}},
                         sum_old[SW-1-i*SUM_W -: SUM_W]};
          end
          uwait_tri_r <= 1'b0;
          state_r     <= T_USTART;
        end
        T_USTART: begin
          state_r <= T_UWAIT;
        end
        T_UWAIT: begin
          if (ursp.done) begin
            if (uwait_tri_r && !ursp.zero) begin
              fn_r    <= ursp.n;
              j_r     <= '0;
              state_r <= T_SUMRD;
            end else begin
              out_n_r     <= uwait_tri_r ? '0 : ursp.n;
              out_zero_r  <= ursp.zero;
              out_valid_r <= 1'b1;
              busy_r      <= 1'b0;
              state_r     <= T_IDLE;
            end
          end
        end
        T_SUMRD: begin
          state_r <= T_SUMWR;
        end
        T_SUMWR: begin
          vld_r[corner[AW-1:0]] <= 1'b1;
          if (j_r == 2'd2) begin
            out_n_r     <= '0;
            out_zero_r  <= 1'b0;
            out_valid_r <= 1'b1;
            busy_r      <= 1'b0;
            state_r     <= T_IDLE;
          end else begin
            j_r     <= j_r + 2'd1;
            state_r <= T_SUMRD;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_n_r[0];
  assign out_normal_y    = out_n_r[1];
  assign out_normal_z    = out_n_r[2];
  assign out_zero_length = out_zero_r;

endmodule

`default_nettype wire

[dv/tb_vertex_normal_accumulator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_accumulator_core
// Drives position writes, triangle adds, normal reads and unused operation
// codes into the vertex normal accumulator and compares every result against
// a built-in fixed-point predictor of the position store and the normal sums.
// ----------------------------------------------------------------------------
module tb_vertex_normal_accumulator_core;
  import vna_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               zero;
  } normal_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = OP_WRITE;
  logic [7:0] in_vertex_a = '0, in_vertex_b = '0, in_vertex_c = '0;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_zero_length;

  longint vertex_pos [256][3];
  longint vertex_sum [256][3];
  bit     pos_written [256];
  normal_result_t expected_normals [$];
  int mismatch_count = 0;

  vertex_normal_accumulator_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_vertex_c(in_vertex_c), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z), .out_valid(out_valid), .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y), .out_normal_z(out_normal_z),
    .out_zero_length(out_zero_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vector(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned m, l2, len, q;
    bit neg [3];
    m = 0;
    l2 = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return 1'b1;
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      m <<= 1;
    end
    for (int i = 0; i < 3; i++) l2 += mag[i] * mag[i];
    len = int_sqrt(l2);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 16384 + (len >> 1)) / len;
      if (q > 16384) q = 16384;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic normal_result_t predict_normal(logic [1:0] op, int a, int b, int c,
                                                    longint px, longint py, longint pz);
    normal_result_t r;
    longint e1 [3], e2 [3], cr [3], fn [3], t;
    r = '0;
    if (op == OP_WRITE) begin
      vertex_pos[a][0] = px;
      vertex_pos[a][1] = py;
      vertex_pos[a][2] = pz;
      pos_written[a] = 1'b1;
    end else if (op == OP_TRI) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = vertex_pos[b][i] - vertex_pos[a][i];
        e2[i] = vertex_pos[c][i] - vertex_pos[a][i];
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if (unit_vector(cr, fn)) begin
        r.zero = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          foreach (e1[k]) begin
            t = vertex_sum[k == 0 ? a : k == 1 ? b : c][i] + fn[i];
            if (t > 8388607) t = 8388607;
            if (t < -8388608) t = -8388608;
            vertex_sum[k == 0 ? a : k == 1 ? b : c][i] = t;
          end
        end
      end
    end else if (op == OP_READ) begin
      r.zero = unit_vector(vertex_sum[a], fn);
      r.nx = 16'(fn[0]);
      r.ny = 16'(fn[1]);
      r.nz = 16'(fn[2]);
    end
    return r;
  endfunction

  task automatic send_command(logic [1:0] op, int a, int b, int c,
                              logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    int gap;
    normal_result_t want;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = predict_normal(op, a, b, c, longint'($signed(px)),
                          longint'($signed(py)), longint'($signed(pz)));
    expected_normals = {expected_normals, want};
    start <= 1'b1;
    in_op <= op;
    in_vertex_a <= 8'(a);
    in_vertex_b <= 8'(b);
    in_vertex_c <= 8'(c);
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  always @(posedge clk) begin
    normal_result_t got, want;
    if (rst_n && out_valid) begin
      got = {out_normal_x, out_normal_y, out_normal_z, out_zero_length};
      if (expected_normals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transaction %h", got);
      end else begin
        want = expected_normals.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected n=(%0d,%0d,%0d) z=%b got n=(%0d,%0d,%0d) z=%b",
                     want.nx, want.ny, want.nz, want.zero,
                     got.nx, got.ny, got.nz, got.zero);
        end
      end
    end
  end

  function automatic logic [15:0] random_pos();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int written_vertex();
    int v;
    do v = $urandom_range(0, 255); while (!pos_written[v]);
    return v;
  endfunction

  task automatic test_directed();
    send_command(OP_READ, 0, 0, 0, 0, 0, 0);
    send_command(OP_READ, 255, 0, 0, 0, 0, 0);
    send_command(OP_WRITE, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
    send_command(OP_WRITE, 1, 0, 0, 16'h2000, 16'h0000, 16'h0000);
    send_command(OP_WRITE, 2, 0, 0, 16'h0000, 16'h2000, 16'h0000);
    send_command(OP_WRITE, 255, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    send_command(OP_WRITE, 254, 0, 0, 16'h8000, 16'h7fff, 16'h8000);
    send_command(OP_TRI, 0, 1, 2, 0, 0, 0);
    send_command(OP_READ, 0, 0, 0, 0, 0, 0);
    send_command(OP_TRI, 0, 0, 1, 0, 0, 0);
    send_command(OP_TRI, 0, 1, 1, 0, 0, 0);
    send_command(OP_TRI, 0, 254, 255, 0, 0, 0);
    send_command(OP_TRI, 255, 254, 1, 0, 0, 0);
    send_command(OP_READ, 255, 0, 0, 0, 0, 0);
    send_command(OP_READ, 254, 0, 0, 0, 0, 0);
    send_command(OP_UNUSED, 255, 255, 255, 16'hffff, 16'hffff, 16'hffff);
    send_command(OP_READ, 3, 0, 0, 0, 0, 0);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 600; i++) send_command(OP_TRI, 0, 1, 2, 0, 0, 0);
    send_command(OP_READ, 1, 0, 0, 0, 0, 0);
    send_command(OP_WRITE, 3, 0, 0, 16'h0000, 16'h0000, 16'h2000);
    for (int i = 0; i < 10; i++) send_command(OP_TRI, 0, 2, 1, 0, 0, 0);
    send_command(OP_READ, 2, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 230; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_command(OP_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), random_pos(), random_pos(),
                              random_pos());
        3, 4, 5, 6: send_command(OP_TRI, written_vertex(), written_vertex(),
                                 written_vertex(), random_pos(), random_pos(),
                                 random_pos());
        7, 8: send_command(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), 0, 0, 0);
        default: send_command(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), random_pos(), random_pos(),
                              random_pos());
      endcase
    end
  endtask

  initial begin
    foreach (vertex_sum[i, j]) begin
      vertex_sum[i][j] = 0;
      vertex_pos[i][j] = 0;
    end
    foreach (pos_written[i]) pos_written[i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_random();
    start <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_normals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[vertex_normal_accumulator_core.f]
rtl/core/vna_pkg.sv
rtl/core/vna_ram.sv
rtl/core/vna_unit.sv
rtl/core/vertex_normal_accumulator_core.sv
dv/tb_vertex_normal_accumulator_core.sv
